// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Types, constants and register indexes shared by the deframer modules.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int TFD_QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] HEAD_VALUE_RESET    = 8'd170;
    localparam logic [BYTE_W-1:0] ADDRESS_VALUE_RESET = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] REG_HEAD_VALUE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_VALUE = 2'd1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEAD,
        PH_FUNC,
        PH_LEN,
        PH_DATA,
        PH_SUMB,
        PH_ADDB
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] data;
        logic              is_lock;
        logic              is_last;
        logic              ok;
    } t_op;

endpackage

// ===== hw/rtl/tfd_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for frame sync, tracks the frame phase and the running checks, and
// queues one operation for every byte that produces results.
// ----------------------------------------------------------------------------
module tfd_front
    import tfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    input  logic [BYTE_W-1:0]      i_in_byte,
    input  logic                   i_q_full,
    output logic                   o_in_stall,
    output logic                   o_push,
    output t_op                    o_op
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_head_value;
    logic [BYTE_W-1:0] r_address_value;
    logic [BYTE_W-1:0] r_run_sum, n_run_sum;
    logic [BYTE_W-1:0] r_run_sos, n_run_sos;
    logic [BYTE_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0] r_received_sum, n_received_sum;
    logic              accept;
    logic [BYTE_W-1:0] lock_sum;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign lock_sum   = r_head_value + i_in_byte;

    always_comb begin
        n_phase        = r_phase;
        n_run_sum      = r_run_sum;
        n_run_sos      = r_run_sos;
        n_bytes_left   = r_bytes_left;
        n_received_sum = r_received_sum;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_in_byte == r_head_value) begin
                        n_phase = PH_HEAD;
                    end
                end
                PH_HEAD: begin
                    if (i_in_byte == r_address_value) begin
                        n_run_sum = lock_sum;
                        n_run_sos = r_head_value + lock_sum;
                        n_phase   = PH_FUNC;
                    end else if (i_in_byte == r_head_value) begin
                        n_phase = PH_HEAD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_FUNC: begin
                    n_run_sum = r_run_sum + i_in_byte;
                    n_run_sos = r_run_sos + n_run_sum;
                    n_phase   = PH_LEN;
                end
                PH_LEN: begin
                    n_run_sum    = r_run_sum + i_in_byte;
                    n_run_sos    = r_run_sos + n_run_sum;
                    n_bytes_left = i_in_byte;
                    n_phase      = (i_in_byte == '0) ? PH_SUMB : PH_DATA;
                end
                PH_DATA: begin
                    n_run_sum = r_run_sum + i_in_byte;
                    n_run_sos = r_run_sos + n_run_sum;
                    if (r_bytes_left != '0) begin
                        n_bytes_left = r_bytes_left - 1'b1;
                    end
                    if (r_bytes_left <= 8'd1) begin
                        n_phase = PH_SUMB;
                    end
                end
                PH_SUMB: begin
                    n_received_sum = i_in_byte;
                    n_phase        = PH_ADDB;
                end
                PH_ADDB: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        o_push       = 1'b0;
        o_op.head    = r_head_value;
        o_op.data    = i_in_byte;
        o_op.is_lock = 1'b0;
        o_op.is_last = 1'b0;
        o_op.ok      = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                o_push = 1'b0;
            end
            PH_HEAD: begin
                o_push       = accept && (i_in_byte == r_address_value);
                o_op.is_lock = 1'b1;
            end
            PH_ADDB: begin
                o_push       = accept;
                o_op.is_last = 1'b1;
                o_op.ok      = (r_received_sum == r_run_sum) && (i_in_byte == r_run_sos);
            end
            PH_FUNC, PH_LEN, PH_DATA, PH_SUMB: begin
                o_push = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT;
            r_head_value    <= HEAD_VALUE_RESET;
            r_address_value <= ADDRESS_VALUE_RESET;
            r_run_sum       <= '0;
            r_run_sos       <= '0;
            r_bytes_left    <= '0;
            r_received_sum  <= '0;
        end else begin
            r_phase        <= n_phase;
            r_run_sum      <= n_run_sum;
            r_run_sos      <= n_run_sos;
            r_bytes_left   <= n_bytes_left;
            r_received_sum <= n_received_sum;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_HEAD_VALUE:    r_head_value    <= i_cfg_data;
                    REG_ADDRESS_VALUE: r_address_value <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/tfd_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer operation queue
// Small first-in first-out store between the front end and the result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tfd_queue
    import tfd_pkg::*;
#(
    parameter int DEPTH = TFD_QUEUE_DEPTH
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_op  o_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT, "queue count overflow")
    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `ASSERT_IMPLIES(a_ptr_match, i_clk, i_rst_n, o_empty || o_full, r_wr_ptr == r_rd_ptr, "pointer mismatch")

endmodule

// ===== hw/rtl/tfd_back.sv =====
// ----------------------------------------------------------------------------
// Deframer result stage
// Expands queued operations into result items held in an output register.
// ----------------------------------------------------------------------------
module tfd_back
    import tfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  t_op               i_op,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_first,
    output logic              o_is_last,
    output logic              o_frame_ok,
    output logic              o_run_last
);

    logic              r_valid;
    logic              r_half, n_half;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_first, n_first;
    logic              r_last, n_last;
    logic              r_ok, n_ok;
    logic              r_run_last, n_run_last;
    logic              load;
    logic              head_part;

    assign load      = !r_valid || !i_out_stall;
    assign head_part = i_op.is_lock && !r_half;
    assign o_pop     = load && !i_q_empty && !head_part;

    always_comb begin
        n_half     = r_half;
        n_byte     = r_byte;
        n_first    = r_first;
        n_last     = r_last;
        n_ok       = r_ok;
        n_run_last = r_run_last;
        if (load && !i_q_empty) begin
            n_half = head_part;
            if (head_part) begin
                n_byte     = i_op.head;
                n_first    = 1'b1;
                n_last     = 1'b0;
                n_ok       = 1'b0;
                n_run_last = 1'b0;
            end else begin
                n_byte     = i_op.data;
                n_first    = 1'b0;
                n_last     = i_op.is_last;
                n_ok       = i_op.ok;
                n_run_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_first    <= n_first;
        r_last     <= n_last;
        r_ok       <= n_ok;
        r_run_last <= n_run_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_half <= n_half;
            if (load) begin
                r_valid <= !i_q_empty;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_is_first  = r_first;
    assign o_is_last   = r_last;
    assign o_frame_ok  = r_ok;
    assign o_run_last  = r_run_last;

endmodule

// ===== hw/rtl/telemetry_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame deframer
// Byte-serial frame sync with sum and sum-of-sums check.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_in_byte
//   out      output     o_out_valid / i_out_stall o_out_byte, o_is_first,
//                                                 o_is_last, o_frame_ok, o_run_last
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while the operation queue has room.
// The first result of a byte passes through the queue and then the output register.
// The locking byte yields two results: the head value, then the address byte.
// The input stalls only when the queue is full; the output register lets the
// queue keep filling while a result waits. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module telemetry_frame_deframer_top
    import tfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = TFD_QUEUE_DEPTH
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_in_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_is_first,
    output logic                   o_is_last,
    output logic                   o_frame_ok,
    output logic                   o_run_last
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_op  push_op;
    t_op  head_op;

    tfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_op        (push_op)
    );

    tfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_op    (head_op)
    );

    tfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_op        (head_op),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_is_first  (o_is_first),
        .o_is_last   (o_is_last),
        .o_frame_ok  (o_frame_ok),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== tb/tb_telemetry_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame deframer testbench
// Drives byte streams of well-formed, corrupted and broken frames into the
// deframer under several head and address settings. A tracking model of the
// frame sync predicts every output item, which the monitor checks in order.
// ----------------------------------------------------------------------------
module tb_telemetry_frame_deframer_top
    import tfd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 240;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              ok;
        logic              run_last;
    } t_frame_out;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [BYTE_W-1:0]      cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic [BYTE_W-1:0]      in_byte     = '0;
    logic                   out_stall   = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_is_first;
    logic                   o_is_last;
    logic                   o_frame_ok;
    logic                   o_run_last;

    logic [BYTE_W-1:0] byte_q[$];
    t_frame_out        frame_out_q[$];

    t_phase            trk_phase;
    logic [BYTE_W-1:0] trk_head;
    logic [BYTE_W-1:0] trk_addr;
    logic [BYTE_W-1:0] trk_sum;
    logic [BYTE_W-1:0] trk_sum_of_sums;
    logic [8:0]        trk_left;
    logic [BYTE_W-1:0] trk_rx_sum;

    int unsigned n_fail     = 0;
    int unsigned n_pushed   = 0;
    int unsigned n_in_acc   = 0;
    int unsigned n_out_acc  = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    telemetry_frame_deframer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (in_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_first  (o_is_first),
        .o_is_last   (o_is_last),
        .o_frame_ok  (o_frame_ok),
        .o_run_last  (o_run_last)
    );

    always #1 i_clk = ~i_clk;

    function void reset_tracker();
        trk_phase       = PH_HUNT;
        trk_head        = HEAD_VALUE_RESET;
        trk_addr        = ADDRESS_VALUE_RESET;
        trk_sum         = '0;
        trk_sum_of_sums = '0;
        trk_left        = '0;
        trk_rx_sum      = '0;
    endfunction

    function void sum_in(logic [BYTE_W-1:0] b);
        trk_sum         = trk_sum + b;
        trk_sum_of_sums = trk_sum_of_sums + trk_sum;
    endfunction

    function void note_out(logic [BYTE_W-1:0] d, logic f, logic l, logic k, logic r);
        frame_out_q.push_back('{data: d, first: f, last: l, ok: k, run_last: r});
    endfunction

    function void track_deframer(logic [BYTE_W-1:0] b);
        logic ok;
        case (trk_phase)
            PH_HUNT: begin
                if (b == trk_head) trk_phase = PH_HEAD;
            end
            PH_HEAD: begin
                if (b == trk_addr) begin
                    trk_sum         = '0;
                    trk_sum_of_sums = '0;
                    sum_in(trk_head);
                    sum_in(b);
                    note_out(trk_head, 1'b1, 1'b0, 1'b0, 1'b0);
                    note_out(b, 1'b0, 1'b0, 1'b0, 1'b1);
                    trk_phase = PH_FUNC;
                end else begin
                    trk_phase = (b == trk_head) ? PH_HEAD : PH_HUNT;
                end
            end
            PH_FUNC: begin
                sum_in(b);
                trk_phase = PH_LEN;
                note_out(b, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            PH_LEN: begin
                sum_in(b);
                trk_left  = {1'b0, b};
                trk_phase = (b == '0) ? PH_SUMB : PH_DATA;
                note_out(b, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            PH_DATA: begin
                sum_in(b);
                if (trk_left != '0) trk_left = trk_left - 9'd1;
                if (trk_left == '0) trk_phase = PH_SUMB;
                note_out(b, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            PH_SUMB: begin
                trk_rx_sum = b;
                trk_phase  = PH_ADDB;
                note_out(b, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            PH_ADDB: begin
                ok = (trk_rx_sum == trk_sum) && (b == trk_sum_of_sums);
                trk_phase = PH_HUNT;
                note_out(b, 1'b0, 1'b1, ok, 1'b1);
            end
            default: trk_phase = PH_HUNT;
        endcase
    endfunction

    // Input driver: an offered item is held until accepted.
    always @(posedge i_clk) begin : drive_in
        bit idle;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                track_deframer(in_byte);
                n_in_acc++;
            end
            if (!in_valid || !o_in_stall) begin
                idle = (n_in_acc < 500 || n_in_acc > 800) && ($urandom_range(99) < 26);
                if (byte_q.size() != 0 && !idle) begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off to fill the block.
    always @(posedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) n_out_acc++;
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (!hold_done && n_out_acc >= 400) begin
                hold_done = 1'b1;
                hold_left = 300;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (n_out_acc < 500 || n_out_acc > 800) &&
                             ($urandom_range(99) < 26);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_frame_out got;
        t_frame_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = '{data: o_out_byte, first: o_is_first, last: o_is_last,
                    ok: o_frame_ok, run_last: o_run_last};
            if (frame_out_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected item: byte %02h first %b last %b ok %b run_last %b",
                             got.data, got.first, got.last, got.ok, got.run_last);
            end else begin
                want = frame_out_q.pop_front();
                if (got.data !== want.data || got.first !== want.first ||
                    got.last !== want.last || got.ok !== want.ok ||
                    got.run_last !== want.run_last) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("item differs: want %02h/%b/%b/%b/%b got %02h/%b/%b/%b/%b",
                                 want.data, want.first, want.last, want.ok, want.run_last,
                                 got.data, got.first, got.last, got.ok, got.run_last);
                end
            end
        end
    end

    task automatic push_byte(logic [BYTE_W-1:0] b);
        byte_q.push_back(b);
        n_pushed++;
    endtask

    task automatic queue_frame(int unsigned len, bit bad);
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] ss;
        logic [BYTE_W-1:0] b;
        int unsigned       i;
        s  = '0;
        ss = '0;
        for (i = 0; i < len + 4; i++) begin
            case (i)
                0:       b = trk_head;
                1:       b = trk_addr;
                3:       b = len[BYTE_W-1:0];
                default: b = BYTE_W'($urandom);
            endcase
            s  = s + b;
            ss = ss + s;
            push_byte(b);
        end
        if (bad) begin
            if ($urandom_range(1)) s = s ^ BYTE_W'($urandom_range(1, 255));
            else                   ss = ss ^ BYTE_W'($urandom_range(1, 255));
        end
        push_byte(s);
        push_byte(ss);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || in_valid || frame_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_HEAD_VALUE)         trk_head = val;
        else if (idx == REG_ADDRESS_VALUE) trk_addr = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random_phase(bit with_long);
        int unsigned       target;
        int unsigned       pick;
        int unsigned       len;
        int unsigned       k;
        logic [BYTE_W-1:0] b;
        target = n_pushed + PHASE_ITEMS;
        if (with_long) queue_frame(255, 1'($urandom_range(1)));
        while (n_pushed < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(8);
                queue_frame(len, $urandom_range(99) < 30);
            end else if (pick < 80) begin
                do b = BYTE_W'($urandom); while (b == trk_head || b == trk_addr);
                push_byte(trk_head);
                push_byte(b);
            end else if (pick < 88) begin
                push_byte(trk_head);
            end else begin
                for (k = 0; k < $urandom_range(1, 4); k++) push_byte(BYTE_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] v;
        reset_tracker();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset settings.
        push_byte(8'h00);
        push_byte(trk_head);
        push_byte(8'h12);
        push_byte(trk_head);
        queue_frame(0, 1'b0);
        byte_q.push_back(8'hFF);
        byte_q.pop_back();
        queue_frame(1, 1'b1);
        push_byte(8'hFF);
        wait_drained();

        // Head equal to address, and writes to unused indexes.
        write_reg(REG_HEAD_VALUE, 8'h5A);
        write_reg(REG_ADDRESS_VALUE, 8'h5A);
        write_reg(REG_SPARE_A, 8'hFF);
        write_reg(REG_SPARE_B, 8'h00);
        queue_frame(0, 1'b0);
        wait_drained();

        write_reg(REG_HEAD_VALUE, 8'h00);
        write_reg(REG_ADDRESS_VALUE, 8'hFF);
        queue_random_phase(1'b0);
        wait_drained();

        write_reg(REG_HEAD_VALUE, 8'hFF);
        write_reg(REG_ADDRESS_VALUE, 8'h00);
        queue_random_phase(1'b1);
        wait_drained();

        write_reg(REG_HEAD_VALUE, BYTE_W'($urandom));
        write_reg(REG_ADDRESS_VALUE, BYTE_W'($urandom));
        write_reg(REG_SPARE_A, BYTE_W'($urandom));
        queue_random_phase(1'b0);
        wait_drained();

        v = BYTE_W'($urandom);
        write_reg(REG_HEAD_VALUE, v);
        write_reg(REG_ADDRESS_VALUE, v);
        queue_random_phase(1'b0);
        wait_drained();

        write_reg(REG_HEAD_VALUE, HEAD_VALUE_RESET);
        write_reg(REG_ADDRESS_VALUE, ADDRESS_VALUE_RESET);
        queue_random_phase(1'b1);
        wait_drained();

        write_reg(REG_HEAD_VALUE, BYTE_W'($urandom));
        write_reg(REG_ADDRESS_VALUE, BYTE_W'($urandom));
        write_reg(REG_SPARE_B, BYTE_W'($urandom));
        queue_random_phase(1'b0);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("telemetry_frame_deframer_top: match");
        end else begin
            $display("telemetry_frame_deframer_top: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("telemetry_frame_deframer_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_front.sv
hw/rtl/tfd_queue.sv
hw/rtl/tfd_back.sv
hw/rtl/telemetry_frame_deframer_top.sv
tb/tb_telemetry_frame_deframer_top.sv
